FILE: rtl/pascal_subset_lexer_top_assert.svh
// Assertion macros for the lexer RTL, used by pcl_outq.
// Each macro expands to one labelled concurrent assertion, reset-qualified.
`ifndef PASCAL_SUBSET_LEXER_TOP_ASSERT_SVH
`define PASCAL_SUBSET_LEXER_TOP_ASSERT_SVH

// same-cycle implication
`define PCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// next-cycle implication
`define PCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

FILE: rtl/pcl_pkg.sv
// Shared types, token/error codes and keyword table for the lexer.
// No dependencies.
`timescale 1ns / 1ps

package pcl_pkg;

  localparam int KEYWORD_CHARS = 9;
  localparam int LINE_BITS     = 16;

  localparam int KW_COUNT   = 18;
  localparam int KW_MAX_LEN = 9;

  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_NUL    = 8'd0;

  // token codes
  localparam logic [5:0] TOK_INTEGER = 6'd6;
  localparam logic [5:0] TOK_REAL    = 6'd7;
  localparam logic [5:0] TOK_IDENT   = 6'd18;
  localparam logic [5:0] TOK_ASSIGN  = 6'd19;
  localparam logic [5:0] TOK_NE      = 6'd20;
  localparam logic [5:0] TOK_GE      = 6'd21;
  localparam logic [5:0] TOK_LE      = 6'd22;
  localparam logic [5:0] TOK_LT      = 6'd23;
  localparam logic [5:0] TOK_GT      = 6'd24;
  localparam logic [5:0] TOK_EQ      = 6'd25;
  localparam logic [5:0] TOK_COMMA   = 6'd26;
  localparam logic [5:0] TOK_COLON   = 6'd27;
  localparam logic [5:0] TOK_SEMI    = 6'd28;
  localparam logic [5:0] TOK_DOT     = 6'd29;
  localparam logic [5:0] TOK_PLUS    = 6'd30;
  localparam logic [5:0] TOK_MINUS   = 6'd31;
  localparam logic [5:0] TOK_SLASH   = 6'd32;
  localparam logic [5:0] TOK_STAR    = 6'd33;
  localparam logic [5:0] TOK_LPAREN  = 6'd34;
  localparam logic [5:0] TOK_RPAREN  = 6'd35;

  // error codes
  localparam logic [5:0] ERR_REAL    = 6'd0;
  localparam logic [5:0] ERR_IDENT   = 6'd1;
  localparam logic [5:0] ERR_COMMENT = 6'd2;
  localparam logic [5:0] ERR_CHAR    = 6'd3;

  // keywords, right-justified: first char sits in the top used byte
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "program", "begin", "end", "var", "procedure", "const",
    "integer", "real", "if", "else", "then", "read",
    "write", "while", "do", "for", "to", "downto"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd5, 4'd3, 4'd3, 4'd9, 4'd5, 4'd7, 4'd4, 4'd2,
    4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd2, 4'd3, 4'd2, 4'd6
  };

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_NAME, MODE_INT, MODE_FRAC, MODE_SKIP,
    MODE_LT, MODE_GT, MODE_COLON, MODE_COMMENT
  } scan_mode_e;

  typedef struct packed {
    logic       is_error;
    logic [5:0] code;
  } res_t;

  // results of one scanned byte, handed to the output stage
  typedef struct packed {
    logic [1:0]  count;
    res_t        r0;
    res_t        r1;
    logic [15:0] line;
  } scan_out_t;

  typedef struct packed {
    scan_mode_e mode;
    logic       start_name;
    logic       emit;
    res_t       res;
  } idle_t;

  function automatic res_t mk_res(logic is_err, logic [5:0] code);
    res_t r;
    r.is_error = is_err;
    r.code     = code;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
  endfunction

  // start of a fresh lexeme from the idle state
  function automatic idle_t scan_idle(logic [7:0] c);
    idle_t r;
    r.mode       = MODE_IDLE;
    r.start_name = 1'b0;
    r.emit       = 1'b1;
    r.res        = mk_res(1'b0, TOK_IDENT);
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NUL) begin
      r.emit = 1'b0;
    end else if (is_digit(c)) begin
      r.emit = 1'b0;
      r.mode = MODE_INT;
    end else if (is_letter(c)) begin
      r.emit       = 1'b0;
      r.mode       = MODE_NAME;
      r.start_name = 1'b1;
    end else begin
      case (c)
        "<": begin r.emit = 1'b0; r.mode = MODE_LT; end
        ">": begin r.emit = 1'b0; r.mode = MODE_GT; end
        ":": begin r.emit = 1'b0; r.mode = MODE_COLON; end
        "{": begin r.emit = 1'b0; r.mode = MODE_COMMENT; end
        "=": r.res = mk_res(1'b0, TOK_EQ);
        ",": r.res = mk_res(1'b0, TOK_COMMA);
        ";": r.res = mk_res(1'b0, TOK_SEMI);
        ".": r.res = mk_res(1'b0, TOK_DOT);
        "+": r.res = mk_res(1'b0, TOK_PLUS);
        "-": r.res = mk_res(1'b0, TOK_MINUS);
        "/": r.res = mk_res(1'b0, TOK_SLASH);
        "*": r.res = mk_res(1'b0, TOK_STAR);
        "(": r.res = mk_res(1'b0, TOK_LPAREN);
        ")": r.res = mk_res(1'b0, TOK_RPAREN);
        default: r.res = mk_res(1'b1, ERR_CHAR);
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/pcl_scan.sv
// Scanner core: mode register, name buffer, keyword match, line counter.
// Depends on pcl_pkg. Produces up to two results per scanned byte.
`timescale 1ns / 1ps

module pcl_scan #(
  parameter int KeywordChars = 9,
  parameter int LineBits     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  output pcl_pkg::scan_out_t  scan_o
);
  import pcl_pkg::*;

  localparam int LenW = $clog2(KeywordChars + 1);
  localparam int IdxW = $clog2(KeywordChars);

  scan_mode_e          mode_q, mode_d;
  logic [7:0]          buf_q [KeywordChars];
  logic [LenW-1:0]     len_q, len_d;
  logic                ovf_q, ovf_d;
  logic [LineBits-1:0] line_q, line_d;

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic            kw_match;
  logic [5:0]      kw_code;
  res_t            name_res;
  idle_t           idle;
  logic            a_v, b_v, run_idle;
  res_t            a, b;
  logic            alnum;
  logic [LineBits+15:0] line_ext;

  // keyword compare; descending so the lowest table index wins
  always_comb begin
    kw_code  = TOK_IDENT;
    kw_match = 1'b0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      kw_match = (len_q == LenW'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[k])) begin
          kw_match = kw_match &&
                     (buf_q[i] == KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8]);
        end
      end
      if (kw_match) begin
        kw_code = 6'(k);
      end
    end
  end

  assign name_res = mk_res(1'b0, ovf_q ? TOK_IDENT : kw_code);
  assign idle     = scan_idle(byte_i);
  assign alnum    = is_letter(byte_i) || is_digit(byte_i);

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    line_d   = line_q;
    wr_en    = 1'b0;
    wr_idx   = len_q[IdxW-1:0];
    a_v      = 1'b0;
    b_v      = 1'b0;
    a        = name_res;
    b        = mk_res(1'b0, TOK_IDENT);
    run_idle = 1'b0;
    if (byte_i == CH_LF) begin
      // flush the pending lexeme on the old line, then bump the line
      mode_d = MODE_IDLE;
      case (mode_q)
        MODE_NAME:    a_v = 1'b1;
        MODE_INT:     begin a_v = 1'b1; a = mk_res(1'b0, TOK_INTEGER); end
        MODE_FRAC:    begin a_v = 1'b1; a = mk_res(1'b0, TOK_REAL); end
        MODE_LT:      begin a_v = 1'b1; a = mk_res(1'b0, TOK_LT); end
        MODE_GT:      begin a_v = 1'b1; a = mk_res(1'b0, TOK_GT); end
        MODE_COLON:   begin a_v = 1'b1; a = mk_res(1'b0, TOK_COLON); end
        MODE_COMMENT: begin a_v = 1'b1; a = mk_res(1'b1, ERR_COMMENT); end
        default:      a_v = 1'b0;
      endcase
      if (line_q != '1) begin
        line_d = line_q + 1'b1;
      end
    end else begin
      case (mode_q)
        MODE_NAME: begin
          if (alnum) begin
            if (len_q < LenW'(KeywordChars)) begin
              wr_en = 1'b1;
              len_d = len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            a_v      = 1'b1;
            run_idle = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(byte_i)) begin
            mode_d = MODE_INT;
          end else if (byte_i == ".") begin
            mode_d = MODE_FRAC;
          end else if (is_letter(byte_i)) begin
            a_v    = 1'b1;
            b_v    = 1'b1;
            a      = mk_res(1'b1, ERR_IDENT);
            b      = mk_res(1'b0, TOK_IDENT);
            mode_d = MODE_SKIP;
          end else begin
            a_v      = 1'b1;
            a        = mk_res(1'b0, TOK_INTEGER);
            run_idle = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(byte_i)) begin
            mode_d = MODE_FRAC;
          end else if (is_letter(byte_i)) begin
            a_v    = 1'b1;
            b_v    = 1'b1;
            a      = mk_res(1'b1, ERR_REAL);
            b      = mk_res(1'b0, TOK_REAL);
            mode_d = MODE_SKIP;
          end else begin
            a_v      = 1'b1;
            a        = mk_res(1'b0, TOK_REAL);
            run_idle = 1'b1;
          end
        end
        MODE_SKIP: begin
          run_idle = !alnum;
        end
        MODE_LT: begin
          a_v    = 1'b1;
          mode_d = MODE_IDLE;
          if (byte_i == "=") begin
            a = mk_res(1'b0, TOK_LE);
          end else if (byte_i == ">") begin
            a = mk_res(1'b0, TOK_NE);
          end else begin
            a        = mk_res(1'b0, TOK_LT);
            run_idle = 1'b1;
          end
        end
        MODE_GT: begin
          a_v    = 1'b1;
          mode_d = MODE_IDLE;
          if (byte_i == "=") begin
            a = mk_res(1'b0, TOK_GE);
          end else begin
            a        = mk_res(1'b0, TOK_GT);
            run_idle = 1'b1;
          end
        end
        MODE_COLON: begin
          a_v    = 1'b1;
          mode_d = MODE_IDLE;
          if (byte_i == "=") begin
            a = mk_res(1'b0, TOK_ASSIGN);
          end else begin
            a        = mk_res(1'b0, TOK_COLON);
            run_idle = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (byte_i == "}") begin
            mode_d = MODE_IDLE;
          end
        end
        default: run_idle = 1'b1;
      endcase
      if (run_idle) begin
        mode_d = idle.mode;
        if (idle.start_name) begin
          wr_en  = 1'b1;
          wr_idx = '0;
          len_d  = LenW'(1);
          ovf_d  = 1'b0;
        end
      end
    end
  end

  // merge primary results with the one from the restarted lexeme
  assign line_ext = {16'b0, line_q};
  always_comb begin
    scan_o.r0    = a_v ? a : idle.res;
    scan_o.r1    = b_v ? b : idle.res;
    scan_o.count = 2'(a_v) + 2'(b_v) + 2'(run_idle && idle.emit);
    scan_o.line  = line_ext[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      ovf_q  <= 1'b0;
      line_q <= LineBits'(1);
    end else if (fire_i) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KeywordChars; i++) begin
      if (fire_i && wr_en && (wr_idx == IdxW'(i))) begin
        buf_q[i] <= byte_i;
      end
    end
  end

endmodule

FILE: rtl/pcl_outq.sv
// Result pair register: holds the one or two results of a scanned byte
// and hands them out one per handshake. Depends on pcl_pkg.
`timescale 1ns / 1ps

module pcl_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcl_pkg::scan_out_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_error_o,
  output logic [5:0]         code_o,
  output logic [15:0]        line_o,
  output logic               last_o
);
  import pcl_pkg::*;
  `include "pascal_subset_lexer_top_assert.svh"

  scan_out_t  data_q;
  logic [1:0] cnt_q, cnt_d;   // results still to hand out
  logic       head_q, head_d;
  logic       fire;
  res_t       cur;

  assign out_valid_o = (cnt_q != 2'd0);
  assign fire        = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == 2'd0) || (fire && (cnt_q == 2'd1));
  assign cur         = head_q ? data_q.r1 : data_q.r0;
  assign is_error_o  = cur.is_error;
  assign code_o      = cur.code;
  assign line_o      = data_q.line;
  assign last_o      = (cnt_q == 2'd1);

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (push_i) begin
      cnt_d  = data_i.count;
      head_d = 1'b0;
    end else if (fire) begin
      cnt_d  = cnt_q - 2'd1;
      head_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  `PCL_ASSERT_NOW(a_push_room, clk_i, rst_ni, push_i, free_o && (data_i.count != 2'd0))
  `PCL_ASSERT_NOW(a_pair_head, clk_i, rst_ni, cnt_q == 2'd2, !head_q)
  `PCL_ASSERT_NEXT(a_second_of_pair, clk_i, rst_ni,
                   fire && (cnt_q == 2'd2), (cnt_q == 2'd1) && head_q && $stable(data_q))

endmodule

FILE: rtl/pascal_subset_lexer_top.sv
// Lexer top level: input byte register, scanner core and result pair stage.
// Depends on pcl_pkg, pcl_scan and pcl_outq.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  input   | in        | in_valid_i / in_ready_o   | ch_byte_i
//  result  | out       | out_valid_o / out_ready_i | is_error_o code_o line_o last_o
//
// One byte per cycle while the pair stage is free; a byte's results come out of
// the pair register, fed from the input byte register. A byte giving two results
// holds the pair stage for two output handshakes and stalls the input till then.
// Reset sets the scanner idle and the line counter to one; no clearing pass.
// A stalled output backs up through the pair stage to the input register.
`timescale 1ns / 1ps

module pascal_subset_lexer_top #(
  parameter int KeywordChars = pcl_pkg::KEYWORD_CHARS,
  parameter int LineBits     = pcl_pkg::LINE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_error_o,
  output logic [5:0]  code_o,
  output logic [15:0] line_o,
  output logic        last_o
);
  import pcl_pkg::*;

  logic       full_q;
  logic [7:0] byte_q;
  logic       scan_fire;
  logic       pair_free;
  scan_out_t  scan_res;

  assign scan_fire  = full_q && pair_free;
  assign in_ready_o = !full_q || scan_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      full_q <= 1'b1;
    end else if (scan_fire) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= ch_byte_i;
    end
  end

  pcl_scan #(
    .KeywordChars(KeywordChars),
    .LineBits    (LineBits)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(scan_fire),
    .byte_i(byte_q),
    .scan_o(scan_res)
  );

  pcl_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (scan_fire && (scan_res.count != 2'd0)),
    .data_i     (scan_res),
    .free_o     (pair_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_error_o (is_error_o),
    .code_o     (code_o),
    .line_o     (line_o),
    .last_o     (last_o)
  );

endmodule
